FILE: design/rita_pkg.sv
// Shared types, constants and a helper function for the radix integer-to-ASCII converter.
package rita_pkg;

  // ASCII codes used when building the text.
  localparam logic [6:0] SIGN_CHAR   = 7'h2D;
  localparam logic [6:0] DIGIT_BASE  = 7'h30;
  localparam logic [6:0] LETTER_BASE = 7'h41;

  // Accepted range of number bases.
  localparam logic [4:0] MIN_RADIX = 5'd2;
  localparam logic [4:0] MAX_RADIX = 5'd16;

  // Field widths of the stream words.
  localparam int VALUE_FIELD_W = 32;
  localparam int MAX_VALUE_W   = 64;
  localparam int RADIX_W       = 5;
  localparam int DIGIT_W       = 4;
  localparam int CHAR_W        = 7;

  // Quotient bits resolved by the shared divider in one cycle.
  localparam int STEP_BITS = 8;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } rita_state_t;

  // Commands from the sequencer to the divider.
  typedef struct packed {
    logic load;
    logic step;
  } rita_div_ctl_t;

  // Divider status: a digit is finished on done.
  typedef struct packed {
    logic               done;
    logic               quot_zero;
    logic [DIGIT_W-1:0] digit;
  } rita_div_res_t;

  // Commands from the sequencer to the digit stack.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } rita_stk_ctl_t;

  // Fill status of the digit stack.
  typedef struct packed {
    logic empty;
    logic one;
  } rita_stk_stat_t;

  // Maps a digit value to its ASCII character, 0-9 then A-F.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d < DIGIT_W'(10)) begin
      return DIGIT_BASE + d_ext;
    end else begin
      return LETTER_BASE + (d_ext - CHAR_W'(10));
    end
  endfunction

endpackage

FILE: design/rita_div.sv
// Shared restoring divider that peels one digit off the working value per pass.
module rita_div #(
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rita_pkg::rita_div_ctl_t        ctl,
  input  logic [rita_pkg::RADIX_W-1:0]   radix_in,
  input  logic [VALUE_BITS-1:0]          value_in,
  output rita_pkg::rita_div_res_t        res
);

  localparam int DIV_W  = ((VALUE_BITS + rita_pkg::STEP_BITS - 1) / rita_pkg::STEP_BITS)
                          * rita_pkg::STEP_BITS;
  localparam int CHUNKS = DIV_W / rita_pkg::STEP_BITS;
  localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam logic [CNT_W-1:0] LAST_CHUNK = CNT_W'(CHUNKS - 1);

  logic [DIV_W-1:0]                 work;
  logic [DIV_W-1:0]                 work_next;
  logic [rita_pkg::DIGIT_W-1:0]     rem;
  logic [rita_pkg::DIGIT_W-1:0]     rem_next;
  logic [rita_pkg::RADIX_W-1:0]     radix;
  logic [CNT_W-1:0]                 cnt;
  logic                             last_chunk;

  // One slice of restoring division: eight quotient bits against a narrow remainder.
  always_comb begin
    logic [DIV_W-1:0]             w;
    logic [rita_pkg::RADIX_W-1:0] r;
    w = work;
    r = rita_pkg::RADIX_W'(rem);
    for (int i = 0; i < rita_pkg::STEP_BITS; i++) begin
      r = {r[rita_pkg::RADIX_W-2:0], w[DIV_W-1]};
      w = {w[DIV_W-2:0], 1'b0};
      if (r >= radix) begin
        r    = r - radix;
        w[0] = 1'b1;
      end
    end
    work_next = w;
    rem_next  = r[rita_pkg::DIGIT_W-1:0];
  end

  assign last_chunk = (cnt == LAST_CHUNK);

  // The quotient replaces the dividend in place, ready for the next digit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.load) begin
      cnt <= '0;
    end else if (ctl.step) begin
      cnt <= last_chunk ? '0 : cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work  <= DIV_W'(value_in);
      rem   <= '0;
      radix <= radix_in;
    end else if (ctl.step) begin
      work <= work_next;
      rem  <= last_chunk ? '0 : rem_next;
    end
  end

  assign res.done      = ctl.step & last_chunk;
  assign res.quot_zero = (work_next == '0);
  assign res.digit     = rem_next;

endmodule

FILE: design/rita_stack.sv
// Last-in first-out shift stack that reverses the digit order for output.
module rita_stack #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rita_pkg::rita_stk_ctl_t       ctl,
  input  logic [rita_pkg::DIGIT_W-1:0]  digit_in,
  output logic [rita_pkg::DIGIT_W-1:0]  top,
  output rita_pkg::rita_stk_stat_t      stat
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [rita_pkg::DIGIT_W-1:0] entry [VALUE_BITS];
  logic [CNT_W-1:0]             count;

  // Fill count; payload entries need no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + CNT_W'(1);
    end else if (ctl.pop) begin
      count <= count - CNT_W'(1);
    end
  end

  // A push moves every entry one place deeper; a pop brings them back up.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry[0] <= digit_in;
      for (int i = 1; i < VALUE_BITS; i++) begin
        entry[i] <= entry[i-1];
      end
    end else if (ctl.pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        entry[i] <= entry[i+1];
      end
    end
  end

  assign top        = entry[0];
  assign stat.empty = (count == '0);
  assign stat.one   = (count == CNT_W'(1));

endmodule

FILE: design/radix_integer_to_ascii.sv
// Each digit is divided out in chunks of eight quotient bits and pushed onto the digit stack; then
// each character (sign included) is moved into the output register, most significant digit first.
// Throughput: one number at a time; the next word is taken once the last character is queued.
// The divider loop resolves eight quotient bits per cycle for every digit.
// Reset (synchronous, active high) returns the sequencer to idle and empties the output.
// Words with a base outside 2 to 16 are taken and dropped without output.
module radix_integer_to_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [5:0]  s_axis_tuser,   // [4:0] radix, [5] as_signed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] char_code, [7] zero
  output logic        m_axis_tlast    // last
);

  rita_pkg::rita_state_t       state;
  rita_pkg::rita_state_t       state_next;
  logic                        sign_pend;
  logic                        sign_pend_next;
  logic                        out_valid;
  logic                        out_valid_next;
  logic [rita_pkg::CHAR_W-1:0] out_char;
  logic [rita_pkg::CHAR_W-1:0] out_char_next;
  logic                        out_last;
  logic                        out_last_next;

  logic [rita_pkg::MAX_VALUE_W-1:0] value_wide;
  logic [VALUE_BITS-1:0]            value_in;
  logic [VALUE_BITS-1:0]            magnitude;
  logic [rita_pkg::RADIX_W-1:0]     radix_in;
  logic                             negative;
  logic                             radix_ok;
  logic                             slot_free;

  rita_pkg::rita_div_ctl_t      div_ctl;
  rita_pkg::rita_div_res_t      div_res;
  rita_pkg::rita_stk_ctl_t      stk_ctl;
  rita_pkg::rita_stk_stat_t     stk_stat;
  logic [rita_pkg::DIGIT_W-1:0] stk_top;

  // Input word decode and magnitude.
  assign value_wide = rita_pkg::MAX_VALUE_W'(s_axis_tdata);
  assign value_in   = value_wide[VALUE_BITS-1:0];
  assign radix_in   = s_axis_tuser[4:0];
  assign negative   = s_axis_tuser[5] & value_in[VALUE_BITS-1];
  assign magnitude  = negative ? (~value_in + VALUE_BITS'(1)) : value_in;
  assign radix_ok   = (radix_in >= rita_pkg::MIN_RADIX) && (radix_in <= rita_pkg::MAX_RADIX);
  assign slot_free  = ~out_valid | m_axis_tready;

  rita_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .radix_in (radix_in),
    .value_in (magnitude),
    .res      (div_res)
  );

  rita_stack #(
    .VALUE_BITS (VALUE_BITS)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .ctl      (stk_ctl),
    .digit_in (div_res.digit),
    .top      (stk_top),
    .stat     (stk_stat)
  );

  // Sequencer: divide out the digits, then emit sign and digits most significant first.
  always_comb begin
    state_next     = state;
    sign_pend_next = sign_pend;
    out_valid_next = out_valid & ~m_axis_tready;
    out_char_next  = out_char;
    out_last_next  = out_last;
    s_axis_tready  = 1'b0;
    div_ctl        = '0;
    stk_ctl        = '0;
    unique case (state)
      rita_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && radix_ok) begin
          div_ctl.load   = 1'b1;
          stk_ctl.clear  = 1'b1;
          sign_pend_next = negative;
          state_next     = rita_pkg::ST_DIVIDE;
        end
      end
      rita_pkg::ST_DIVIDE: begin
        div_ctl.step = 1'b1;
        if (div_res.done) begin
          stk_ctl.push = 1'b1;
          if (div_res.quot_zero) begin
            state_next = rita_pkg::ST_EMIT;
          end
        end
      end
      rita_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          if (sign_pend) begin
            out_char_next  = rita_pkg::SIGN_CHAR;
            out_last_next  = 1'b0;
            sign_pend_next = 1'b0;
          end else begin
            stk_ctl.pop   = 1'b1;
            out_char_next = rita_pkg::digit_char(stk_top);
            out_last_next = stk_stat.one;
            if (stk_stat.one) begin
              state_next = rita_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = rita_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rita_pkg::ST_IDLE;
      sign_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sign_pend <= sign_pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_char};
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  // A new word is only taken once every digit of the previous one has left the stack.
  a_idle_stack_empty: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> stk_stat.empty)
    else $error("digit stack not empty while taking a new word");

  // While emitting there is always a sign or a digit still to send.
  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == rita_pkg::ST_EMIT) |-> (sign_pend || !stk_stat.empty))
    else $error("emit state entered with nothing to send");

  // The minus sign never closes a number.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[6:0] == rita_pkg::SIGN_CHAR)) |-> !m_axis_tlast)
    else $error("minus sign marked as last character");

  // A digit pass ends with a push into the stack.
  a_done_pushes: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (stk_ctl.push && (state == rita_pkg::ST_DIVIDE)))
    else $error("finished digit not stored");
`endif

endmodule
